// ===== rtl/core/i2cbm_pkg.sv =====
`timescale 1ns / 1ps

package i2cbm_pkg;

    // phase codes of the bus sequencer
    localparam int PHASE_W = 4;
    typedef logic [PHASE_W-1:0] phase_t;

    localparam phase_t PH_IDLE    = 4'd0;
    localparam phase_t PH_ST_A    = 4'd1;
    localparam phase_t PH_ST_B    = 4'd2;
    localparam phase_t PH_SP_A    = 4'd3;
    localparam phase_t PH_SP_B    = 4'd4;
    localparam phase_t PH_W_SETUP = 4'd5;
    localparam phase_t PH_W_HIGH  = 4'd6;
    localparam phase_t PH_W_LOW   = 4'd7;
    localparam phase_t PH_A_REL   = 4'd8;
    localparam phase_t PH_A_HIGH  = 4'd9;
    localparam phase_t PH_A_POLL  = 4'd10;
    localparam phase_t PH_R_LOW   = 4'd11;
    localparam phase_t PH_R_HIGH  = 4'd12;
    localparam phase_t PH_K_SETUP = 4'd13;
    localparam phase_t PH_K_HIGH  = 4'd14;

    // request opcodes
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_UNIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT    = 2'd1;

    localparam logic [15:0] TICKS_RESET   = 16'd72;
    localparam logic [15:0] TIMEOUT_RESET = 16'd250;

    localparam logic [7:0] MSB_MASK = 8'h80;
    localparam int DELAY_W = 20;

    // segment lengths in delay units
    localparam logic [2:0] UNITS_1 = 3'd1;
    localparam logic [2:0] UNITS_2 = 3'd2;
    localparam logic [2:0] UNITS_5 = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } req_t;

    typedef struct packed {
        logic       scl;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       no_ack;
    } res_t;

    typedef struct packed {
        logic [15:0] ticks_per_unit;
        logic [15:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic [3:0]         bit_count;
        logic [7:0]         shift_reg;
        logic [DELAY_W-1:0] delay_count;
        logic [15:0]        timeout_count;
        logic               scl;
        logic               sda;
        logic               drive;
        logic [7:0]         rx;
        logic               nack;
        logic               ack_choice;
    } state_t;

    // ticks in a segment of the given unit count, zero tick count acts as one
    function automatic logic [DELAY_W-1:0] seg_ticks(input logic [2:0] units,
                                                     input logic [15:0] tpu);
        logic [DELAY_W-1:0] t;
        logic [DELAY_W-1:0] r;
        t = (tpu == 16'd0) ? DELAY_W'(1) : DELAY_W'(tpu);
        unique case (units)
            UNITS_2: r = t << 1;
            UNITS_5: r = (t << 2) + t;
            default: r = t;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/i2cbm_if.sv =====
`timescale 1ns / 1ps

interface i2cbm_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, op, write_data, send_ack, sda_in, input ready);
    modport sink   (input valid, op, write_data, send_ack, sda_in, output ready);
endinterface

interface i2cbm_res_if;
    logic       valid;
    logic       ready;
    logic       scl;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       no_ack;

    modport source (output valid, scl, sda_level, sda_drive, busy_res, done_res,
                    read_data, no_ack, input ready);
    modport sink   (input valid, scl, sda_level, sda_drive, busy_res, done_res,
                    read_data, no_ack, output ready);
endinterface

interface i2cbm_cfg_if import i2cbm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/i2cbm_cfg_regs.sv =====
`timescale 1ns / 1ps

module i2cbm_cfg_regs import i2cbm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    i2cbm_cfg_if.sink   cfg,
    output cfg_t        cfg_q
);

    logic [15:0] ticks_reg;
    logic [15:0] timeout_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg   <= TICKS_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg.valid)
        begin
            // writes to unknown indexes are dropped
            if (cfg.index == CFG_TICKS_PER_UNIT)
                ticks_reg <= cfg.data;
            if (cfg.index == CFG_ACK_TIMEOUT)
                timeout_reg <= cfg.data;
        end
    end

    assign cfg_q.ticks_per_unit = ticks_reg;
    assign cfg_q.ack_timeout    = timeout_reg;

endmodule

// ===== rtl/core/i2cbm_step.sv =====
`timescale 1ns / 1ps

module i2cbm_step import i2cbm_pkg::*; (
    input  state_t state,
    input  req_t   req,
    input  cfg_t   cfg,
    output state_t state_next,
    output logic   done
);

    logic [DELAY_W-1:0] dec;
    logic               is_cmd;

    assign is_cmd = (state.phase == PH_IDLE) && (req.op >= OP_START) && (req.op <= OP_READ);

    always_comb
    begin
        state_next = state;
        done       = 1'b0;
        dec        = (state.delay_count != '0) ? state.delay_count - DELAY_W'(1) : '0;
        if (is_cmd)
        begin
            state_next.bit_count = 4'd0;
            unique case (req.op)
                OP_START:
                begin
                    state_next.drive       = 1'b1;
                    state_next.sda         = 1'b1;
                    state_next.scl         = 1'b1;
                    state_next.phase       = PH_ST_A;
                    state_next.delay_count = seg_ticks(UNITS_5, cfg.ticks_per_unit);
                end
                OP_STOP:
                begin
                    state_next.scl         = 1'b0;
                    state_next.sda         = 1'b0;
                    state_next.drive       = 1'b1;
                    state_next.phase       = PH_SP_A;
                    state_next.delay_count = seg_ticks(UNITS_5, cfg.ticks_per_unit);
                end
                OP_WRITE:
                begin
                    state_next.nack        = 1'b0;
                    state_next.shift_reg   = req.write_data;
                    state_next.drive       = 1'b1;
                    state_next.scl         = 1'b0;
                    state_next.sda         = |(req.write_data & MSB_MASK);
                    state_next.phase       = PH_W_SETUP;
                    state_next.delay_count = seg_ticks(UNITS_2, cfg.ticks_per_unit);
                end
                default:
                begin
                    state_next.ack_choice  = req.send_ack;
                    state_next.shift_reg   = 8'd0;
                    state_next.drive       = 1'b0;
                    state_next.sda         = 1'b1;
                    state_next.scl         = 1'b0;
                    state_next.phase       = PH_R_LOW;
                    state_next.delay_count = seg_ticks(UNITS_2, cfg.ticks_per_unit);
                end
            endcase
        end
        else if (state.phase == PH_IDLE)
        begin
            state_next = state;
        end
        else if (state.phase == PH_A_POLL)
        begin
            if (!req.sda_in)
            begin
                state_next.scl   = 1'b0;
                state_next.phase = PH_IDLE;
                done             = 1'b1;
            end
            else if (state.timeout_count >= cfg.ack_timeout)
            begin
                // give up: flag and run a stop
                state_next.nack        = 1'b1;
                state_next.scl         = 1'b0;
                state_next.sda         = 1'b0;
                state_next.drive       = 1'b1;
                state_next.phase       = PH_SP_A;
                state_next.delay_count = seg_ticks(UNITS_5, cfg.ticks_per_unit);
            end
            else
            begin
                state_next.timeout_count = state.timeout_count + 16'd1;
            end
        end
        else
        begin
            state_next.delay_count = dec;
            if (dec == '0)
            begin
                if (state.phase == PH_R_LOW)
                begin
                    state_next.scl         = 1'b1;
                    state_next.shift_reg   = {state.shift_reg[6:0], req.sda_in};
                    state_next.phase       = PH_R_HIGH;
                    state_next.delay_count = seg_ticks(UNITS_1, cfg.ticks_per_unit);
                end
                else
                begin
                    unique case (state.phase)
                        PH_ST_A:
                        begin
                            state_next.sda         = 1'b0;
                            state_next.phase       = PH_ST_B;
                            state_next.delay_count = seg_ticks(UNITS_5, cfg.ticks_per_unit);
                        end
                        PH_ST_B:
                        begin
                            state_next.scl   = 1'b0;
                            state_next.phase = PH_IDLE;
                            done             = 1'b1;
                        end
                        PH_SP_A:
                        begin
                            state_next.scl         = 1'b1;
                            state_next.sda         = 1'b1;
                            state_next.phase       = PH_SP_B;
                            state_next.delay_count = seg_ticks(UNITS_5, cfg.ticks_per_unit);
                        end
                        PH_SP_B:
                        begin
                            state_next.phase = PH_IDLE;
                            done             = 1'b1;
                        end
                        PH_W_SETUP:
                        begin
                            state_next.scl         = 1'b1;
                            state_next.phase       = PH_W_HIGH;
                            state_next.delay_count = seg_ticks(UNITS_2, cfg.ticks_per_unit);
                        end
                        PH_W_HIGH:
                        begin
                            state_next.scl         = 1'b0;
                            state_next.phase       = PH_W_LOW;
                            state_next.delay_count = seg_ticks(UNITS_2, cfg.ticks_per_unit);
                        end
                        PH_W_LOW:
                        begin
                            state_next.bit_count = state.bit_count + 4'd1;
                            state_next.shift_reg = {state.shift_reg[6:0], 1'b0};
                            if (state_next.bit_count < 4'd8)
                            begin
                                state_next.sda         = |(state_next.shift_reg & MSB_MASK);
                                state_next.phase       = PH_W_SETUP;
                                state_next.delay_count =
                                    seg_ticks(UNITS_2, cfg.ticks_per_unit);
                            end
                            else
                            begin
                                // release sda for the acknowledge
                                state_next.drive       = 1'b0;
                                state_next.sda         = 1'b1;
                                state_next.phase       = PH_A_REL;
                                state_next.delay_count =
                                    seg_ticks(UNITS_1, cfg.ticks_per_unit);
                            end
                        end
                        PH_A_REL:
                        begin
                            state_next.scl         = 1'b1;
                            state_next.phase       = PH_A_HIGH;
                            state_next.delay_count = seg_ticks(UNITS_1, cfg.ticks_per_unit);
                        end
                        PH_A_HIGH:
                        begin
                            state_next.timeout_count = 16'd0;
                            state_next.phase         = PH_A_POLL;
                        end
                        PH_R_HIGH:
                        begin
                            state_next.bit_count = state.bit_count + 4'd1;
                            state_next.scl       = 1'b0;
                            if (state_next.bit_count < 4'd8)
                            begin
                                state_next.phase       = PH_R_LOW;
                                state_next.delay_count =
                                    seg_ticks(UNITS_2, cfg.ticks_per_unit);
                            end
                            else
                            begin
                                state_next.drive       = 1'b1;
                                state_next.sda         = ~state.ack_choice;
                                state_next.phase       = PH_K_SETUP;
                                state_next.delay_count =
                                    seg_ticks(UNITS_2, cfg.ticks_per_unit);
                            end
                        end
                        PH_K_SETUP:
                        begin
                            state_next.scl         = 1'b1;
                            state_next.phase       = PH_K_HIGH;
                            state_next.delay_count = seg_ticks(UNITS_5, cfg.ticks_per_unit);
                        end
                        PH_K_HIGH:
                        begin
                            state_next.scl   = 1'b0;
                            state_next.rx    = state.shift_reg;
                            state_next.phase = PH_IDLE;
                            done             = 1'b1;
                        end
                        default:
                        begin
                            state_next.phase = PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

endmodule

// ===== rtl/core/i2c_bit_master_top.sv =====
`timescale 1ns / 1ps

// bit-level i2c master: every request on req is one bus tick, and while the
// sequencer is idle a request may carry a command instead (start, stop, write
// a byte and wait for the acknowledge, read a byte and send ack or nack).
// each request gives exactly one result on res with the scl/sda levels to
// drive, busy, a done pulse, the last read byte and the no-ack flag. one
// request is taken per clock while res is not held; a request passes an input
// register and then the sequencer step into the result register, from which
// its result is shown on res. both sides stall together when res is held.
// segment lengths are multiples of ticks_per_unit ticks (config index 0);
// ack_timeout (index 1) bounds the acknowledge polling. configuration is to be written by
// the user only while no request is in flight; the block does not enforce it.

module i2c_bit_master_top import i2cbm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    i2cbm_req_if.sink  req,
    i2cbm_res_if.source res,
    i2cbm_cfg_if.sink  cfg
);

    // pipeline control
    logic   advance;
    logic   req_valid_reg;
    req_t   req_reg;
    logic   res_valid_reg;
    res_t   res_reg;

    // sequencer state
    state_t state_reg;
    state_t state_next;
    logic   step_done;
    cfg_t   cfg_q;

    // whole pipe moves when the result slot is free or being emptied
    assign advance   = !res_valid_reg || res.ready;
    assign req.ready = advance;

    i2cbm_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    i2cbm_step u_step (
        .state      (state_reg),
        .req        (req_reg),
        .cfg        (cfg_q),
        .state_next (state_next),
        .done       (step_done)
    );

    // input register, payload needs no reset
    always_ff @(posedge clk)
    begin
        if (advance && req.valid)
        begin
            req_reg.op         <= req.op;
            req_reg.write_data <= req.write_data;
            req_reg.send_ack   <= req.send_ack;
            req_reg.sda_in     <= req.sda_in;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            req_valid_reg <= req.valid;
            res_valid_reg <= req_valid_reg;
        end
    end

    // sequencer state, bus idle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_IDLE;
            state_reg.bit_count     <= 4'd0;
            state_reg.shift_reg     <= 8'd0;
            state_reg.delay_count   <= '0;
            state_reg.timeout_count <= 16'd0;
            state_reg.scl           <= 1'b1;
            state_reg.sda           <= 1'b1;
            state_reg.drive         <= 1'b1;
            state_reg.rx            <= 8'd0;
            state_reg.nack          <= 1'b0;
            state_reg.ack_choice    <= 1'b0;
        end
        else if (advance && req_valid_reg)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance && req_valid_reg)
        begin
            res_reg.scl       <= state_next.scl;
            res_reg.sda_level <= state_next.sda;
            res_reg.sda_drive <= state_next.drive;
            res_reg.busy_res  <= (state_next.phase != PH_IDLE);
            res_reg.done_res  <= step_done;
            res_reg.read_data <= state_next.rx;
            res_reg.no_ack    <= state_next.nack;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.scl       = res_reg.scl;
    assign res.sda_level = res_reg.sda_level;
    assign res.sda_drive = res_reg.sda_drive;
    assign res.busy_res  = res_reg.busy_res;
    assign res.done_res  = res_reg.done_res;
    assign res.read_data = res_reg.read_data;
    assign res.no_ack    = res_reg.no_ack;

    // a completing command always leaves the sequencer idle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.done_res |-> !res_reg.busy_res)
        else $error("done reported while still busy");

    // sda is released while polling for the acknowledge
    a_poll_released: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_A_POLL |-> !state_reg.drive)
        else $error("sda driven during acknowledge poll");

    // the sequencer moves only on a request that reaches the result register
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && req_valid_reg) |=> $stable(state_reg))
        else $error("sequencer state changed without a request");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import i2cbm_pkg::*;

    // unused opcodes, the block takes them as plain ticks
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 400;
    localparam int QUIET_LIMIT   = 2000;
    localparam int ERROR_PRINTS  = 100;
    localparam int NEVER_ACK     = 1 << 30;

    localparam int RANDOM_ITEMS    = 150;
    localparam int RANDOM_COMMANDS = 6;

    // bus sequencer state as the predictor keeps it
    typedef struct packed {
        phase_t      ph;
        logic [3:0]  bit_cnt;
        logic [7:0]  shifter;
        logic [19:0] delay;
        logic [15:0] polls;
        logic        scl;
        logic        sda;
        logic        drive;
        logic [7:0]  rx;
        logic        nack;
        logic        ack_sel;
    } bus_state_t;

    localparam bus_state_t BUS_RESET = '{
        ph: PH_IDLE, bit_cnt: '0, shifter: '0, delay: '0, polls: '0,
        scl: 1'b1, sda: 1'b1, drive: 1'b1, rx: '0, nack: 1'b0, ack_sel: 1'b0
    };

    localparam cfg_t CFG_RESET = '{ticks_per_unit: TICKS_RESET, ack_timeout: TIMEOUT_RESET};

    logic clk;
    logic rst_n;

    i2cbm_req_if req_ch ();
    i2cbm_res_if res_ch ();
    i2cbm_cfg_if cfg_ch ();

    i2c_bit_master_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // predictor state follows accepted requests, planner state follows the queue
    bus_state_t live_state;
    bus_state_t plan_state;
    cfg_t       live_cfg;
    cfg_t       plan_cfg;

    req_t queued_requests[$];
    res_t expected_levels[$];

    int unsigned issued;
    int unsigned retired;
    int unsigned failures;
    int unsigned mismatch_prints;
    int unsigned completions;
    int unsigned reg_writes;
    int unsigned active_items;
    int unsigned command_count;
    int unsigned ack_timeouts;

    int burst_left;
    int gap_left;
    int hold_left;
    int pattern_left;
    int stall_pct;
    int quiet_cycles;
    bit stall_request;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ticks in a segment of n delay units, zero length unit counts as one tick
    function automatic logic [19:0] seg_len(input int unsigned units, input logic [15:0] tpu);
        int unsigned per_unit;
        per_unit = (tpu == 16'd0) ? 1 : tpu;
        return 20'(units * per_unit);
    endfunction

    function automatic void enter_stop(inout bus_state_t s, input logic [15:0] tpu);
        s.scl   = 1'b0;
        s.sda   = 1'b0;
        s.drive = 1'b1;
        s.ph    = PH_SP_A;
        s.delay = seg_len(5, tpu);
    endfunction

    // end of a timed segment, returns 1 when the command completes
    function automatic bit end_segment(inout bus_state_t s, input logic [15:0] tpu);
        bit done;
        done = 1'b0;
        case (s.ph)
            PH_ST_A:
            begin
                s.sda = 1'b0;
                s.ph = PH_ST_B;
                s.delay = seg_len(5, tpu);
            end
            PH_ST_B:
            begin
                s.scl = 1'b0;
                s.ph = PH_IDLE;
                done = 1'b1;
            end
            PH_SP_A:
            begin
                s.scl = 1'b1;
                s.sda = 1'b1;
                s.ph = PH_SP_B;
                s.delay = seg_len(5, tpu);
            end
            PH_SP_B:
            begin
                s.ph = PH_IDLE;
                done = 1'b1;
            end
            PH_W_SETUP:
            begin
                s.scl = 1'b1;
                s.ph = PH_W_HIGH;
                s.delay = seg_len(2, tpu);
            end
            PH_W_HIGH:
            begin
                s.scl = 1'b0;
                s.ph = PH_W_LOW;
                s.delay = seg_len(2, tpu);
            end
            PH_W_LOW:
            begin
                s.bit_cnt = s.bit_cnt + 4'd1;
                s.shifter = s.shifter << 1;
                if (s.bit_cnt < 4'd8)
                begin
                    s.sda = |(s.shifter & MSB_MASK);
                    s.ph = PH_W_SETUP;
                    s.delay = seg_len(2, tpu);
                end
                else
                begin
                    s.drive = 1'b0;
                    s.sda = 1'b1;
                    s.ph = PH_A_REL;
                    s.delay = seg_len(1, tpu);
                end
            end
            PH_A_REL:
            begin
                s.scl = 1'b1;
                s.ph = PH_A_HIGH;
                s.delay = seg_len(1, tpu);
            end
            PH_A_HIGH:
            begin
                s.polls = '0;
                s.ph = PH_A_POLL;
            end
            PH_R_HIGH:
            begin
                s.bit_cnt = s.bit_cnt + 4'd1;
                s.scl = 1'b0;
                if (s.bit_cnt < 4'd8)
                begin
                    s.ph = PH_R_LOW;
                    s.delay = seg_len(2, tpu);
                end
                else
                begin
                    s.drive = 1'b1;
                    s.sda = !s.ack_sel;
                    s.ph = PH_K_SETUP;
                    s.delay = seg_len(2, tpu);
                end
            end
            PH_K_SETUP:
            begin
                s.scl = 1'b1;
                s.ph = PH_K_HIGH;
                s.delay = seg_len(5, tpu);
            end
            PH_K_HIGH:
            begin
                s.scl = 1'b0;
                s.rx = s.shifter;
                s.ph = PH_IDLE;
                done = 1'b1;
            end
            default: s.ph = PH_IDLE;
        endcase
        return done;
    endfunction

    // one request through the bus sequencer, gives the line levels after it
    function automatic res_t bus_step(inout bus_state_t s, input cfg_t c, input req_t r);
        res_t o;
        bit done;
        logic [15:0] tpu;
        done = 1'b0;
        tpu = c.ticks_per_unit;
        if (s.ph == PH_IDLE && r.op >= OP_START && r.op <= OP_READ)
        begin
            s.bit_cnt = '0;
            case (r.op)
                OP_START:
                begin
                    s.drive = 1'b1;
                    s.sda = 1'b1;
                    s.scl = 1'b1;
                    s.ph = PH_ST_A;
                    s.delay = seg_len(5, tpu);
                end
                OP_STOP: enter_stop(s, tpu);
                OP_WRITE:
                begin
                    s.nack = 1'b0;
                    s.shifter = r.write_data;
                    s.drive = 1'b1;
                    s.scl = 1'b0;
                    s.sda = |(r.write_data & MSB_MASK);
                    s.ph = PH_W_SETUP;
                    s.delay = seg_len(2, tpu);
                end
                default:
                begin
                    s.ack_sel = r.send_ack;
                    s.shifter = '0;
                    s.drive = 1'b0;
                    s.sda = 1'b1;
                    s.scl = 1'b0;
                    s.ph = PH_R_LOW;
                    s.delay = seg_len(2, tpu);
                end
            endcase
        end
        else if (s.ph == PH_A_POLL)
        begin
            if (!r.sda_in)
            begin
                s.scl = 1'b0;
                s.ph = PH_IDLE;
                done = 1'b1;
            end
            else if (s.polls >= c.ack_timeout)
            begin
                s.nack = 1'b1;
                enter_stop(s, tpu);
            end
            else
                s.polls = s.polls + 16'd1;
        end
        else if (s.ph != PH_IDLE)
        begin
            if (s.delay != '0)
                s.delay = s.delay - 20'd1;
            if (s.delay == '0)
            begin
                if (s.ph == PH_R_LOW)
                begin
                    s.scl = 1'b1;
                    s.shifter = {s.shifter[6:0], r.sda_in};
                    s.ph = PH_R_HIGH;
                    s.delay = seg_len(1, tpu);
                end
                else
                    done = end_segment(s, tpu);
            end
        end
        o.scl       = s.scl;
        o.sda_level = s.sda;
        o.sda_drive = s.drive;
        o.busy_res  = (s.ph != PH_IDLE);
        o.done_res  = done;
        o.read_data = s.rx;
        o.no_ack    = s.nack;
        return o;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            failures++;
            if (mismatch_prints < ERROR_PRINTS)
            begin
                mismatch_prints++;
                $error("%s: expected %0h, got %0h", name, want, got);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // request planning: the planner steps its own copy of the sequencer so
    // that commands land while idle and acks land inside the polling window
    // ---------------------------------------------------------------

    task automatic offer(input req_t r);
        res_t ignored;
        if (plan_state.ph != PH_IDLE || (r.op >= OP_START && r.op <= OP_READ))
            active_items++;
        queued_requests.push_back(r);
        ignored = bus_step(plan_state, plan_cfg, r);
    endtask

    // tick while busy, now and then carrying a command or an unused opcode
    function automatic req_t busy_tick(input logic sda);
        req_t r;
        r.op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(OP_TICK, OP_UNUSED_HI)) : OP_TICK;
        r.write_data = 8'($urandom);
        r.send_ack = 1'($urandom);
        r.sda_in = sda;
        return r;
    endfunction

    // ticks while idle, plain or with an unused opcode
    task automatic idle_gap(input int n);
        req_t r;
        for (int k = 0; k < n; k++)
        begin
            r = busy_tick(1'($urandom));
            r.op = $urandom_range(0, 1) ? OP_TICK : 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            offer(r);
        end
    endtask

    // issue one command and tick until it completes; for reads data is the
    // byte the target puts on sda, for writes ack_wait is the number of
    // high samples before the target pulls sda low
    task automatic run_command(input logic [2:0] op, input logic [7:0] data, input logic ack,
                               input int ack_wait);
        req_t r;
        int highs;
        logic sda;
        highs = 0;
        r = busy_tick(1'($urandom));
        r.op = op;
        r.write_data = data;
        r.send_ack = ack;
        offer(r);
        while (plan_state.ph != PH_IDLE)
        begin
            if (plan_state.ph == PH_A_POLL)
            begin
                sda = (highs >= ack_wait) ? 1'b0 : 1'b1;
                highs++;
            end
            else if (plan_state.ph == PH_R_LOW)
                sda = data[3'd7 - plan_state.bit_cnt[2:0]];
            else
                sda = 1'($urandom);
            offer(busy_tick(sda));
        end
        command_count++;
        if (op == OP_WRITE && plan_state.nack)
            ack_timeouts++;
    endtask

    // well-formed transfer: start, address, data bytes, stop
    task automatic random_transfer();
        int nbytes;
        bit reading;
        nbytes = $urandom_range(1, 3);
        reading = 1'($urandom);
        run_command(OP_START, 8'($urandom), 1'($urandom), 0);
        idle_gap($urandom_range(0, 2));
        run_command(OP_WRITE, {7'($urandom), reading}, 1'($urandom),
                    $urandom_range(0, plan_cfg.ack_timeout));
        for (int k = 0; k < nbytes; k++)
        begin
            if (reading)
                run_command(OP_READ, 8'($urandom), k != nbytes - 1, 0);
            else
                run_command(OP_WRITE, 8'($urandom), 1'($urandom),
                            $urandom_range(0, plan_cfg.ack_timeout));
            idle_gap($urandom_range(0, 1));
        end
        run_command(OP_STOP, 8'($urandom), 1'($urandom), 0);
    endtask

    // any command alone, the ack may come too late
    task automatic random_lone_command();
        run_command(3'($urandom_range(OP_START, OP_READ)), 8'($urandom), 1'($urandom),
                    $urandom_range(0, plan_cfg.ack_timeout + 2));
    endtask

    // ---------------------------------------------------------------
    // phase control: config only moves once every request has its result
    // ---------------------------------------------------------------

    task automatic wait_drained();
        @(posedge clk);
        while (queued_requests.size() != 0 || issued != retired)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        if (idx == CFG_TICKS_PER_UNIT)
            plan_cfg.ticks_per_unit = value;
        else
            plan_cfg.ack_timeout = value;
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_TICKS_PER_UNIT)
            live_cfg.ticks_per_unit = value;
        else
            live_cfg.ack_timeout = value;
        reg_writes++;
    endtask

    task automatic start_phase(input logic [15:0] tpu, input logic [15:0] timeout);
        wait_drained();
        set_reg(CFG_TICKS_PER_UNIT, tpu);
        set_reg(CFG_ACK_TIMEOUT, timeout);
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // request driver: bursts of random length with random gaps; the
    // prediction is made from what is on the channel when it is taken
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : drive_requests
        req_t next_req;
        res_t predicted;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predicted = bus_step(live_state, live_cfg,
                                     req_t'({req_ch.op, req_ch.write_data,
                                             req_ch.send_ack, req_ch.sda_in}));
                expected_levels.push_back(predicted);
            end
            // a request held without ready stays on the channel
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    req_ch.valid <= 1'b0;
                    gap_left--;
                end
                else if (queued_requests.size() != 0)
                begin
                    next_req = queued_requests.pop_front();
                    issued++;
                    req_ch.valid      <= 1'b1;
                    req_ch.op         <= next_req.op;
                    req_ch.write_data <= next_req.write_data;
                    req_ch.send_ack   <= next_req.send_ack;
                    req_ch.sda_in     <= next_req.sda_in;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        // mostly short bursts, sometimes a long stretch with no gaps
                        burst_left = ($urandom_range(0, 4) == 0) ?
                                     $urandom_range(200, 800) : $urandom_range(1, 48);
                        gap_left = $urandom_range(0, 7);
                    end
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result side: stall density is redrawn whenever its pattern count runs out; a long hold
    // on request backs the block up into its request channel
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_request)
            begin
                stall_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern_left = 256;
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 10;
                        default: stall_pct = 40;
                    endcase
                end
                pattern_left--;
                res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // result monitor: each taken result against the oldest prediction
    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_levels.size() == 0)
            begin
                failures++;
                $error("result with no request outstanding");
            end
            else
            begin
                want = expected_levels.pop_front();
                check_field("scl", 8'(want.scl), 8'(res_ch.scl));
                check_field("sda_level", 8'(want.sda_level), 8'(res_ch.sda_level));
                check_field("sda_drive", 8'(want.sda_drive), 8'(res_ch.sda_drive));
                check_field("busy_res", 8'(want.busy_res), 8'(res_ch.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(res_ch.done_res));
                check_field("read_data", want.read_data, res_ch.read_data);
                check_field("no_ack", 8'(want.no_ack), 8'(res_ch.no_ack));
                if (want.done_res)
                    completions++;
            end
            retired++;
        end
    end

    // watchdog on handshakes of any channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int unsigned directed_commands;
        logic [15:0] tpu;
        logic [15:0] timeout;
        bit held;

        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op = OP_TICK;
        req_ch.write_data = '0;
        req_ch.send_ack = 1'b0;
        req_ch.sda_in = 1'b1;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_TICKS_PER_UNIT;
        cfg_ch.data = '0;
        live_state = BUS_RESET;
        plan_state = BUS_RESET;
        live_cfg = CFG_RESET;
        plan_cfg = CFG_RESET;
        issued = 0;
        retired = 0;
        failures = 0;
        mismatch_prints = 0;
        completions = 0;
        reg_writes = 0;
        active_items = 0;
        command_count = 0;
        ack_timeouts = 0;
        burst_left = 16;
        gap_left = 0;
        hold_left = 0;
        pattern_left = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        stall_request = 1'b0;
        held = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset register values: ignored opcodes while idle, a start timed by
        // the reset unit length, then the reset ack timeout with one-tick units
        for (int k = OP_UNUSED_LO; k <= OP_UNUSED_HI; k++)
        begin
            offer('{op: 3'(k), write_data: 8'hFF, send_ack: 1'b1, sda_in: 1'b0});
            offer('{op: OP_TICK, write_data: 8'h00, send_ack: 1'b0, sda_in: 1'b1});
        end
        run_command(OP_START, 8'h00, 1'b0, 0);
        wait_drained();
        set_reg(CFG_TICKS_PER_UNIT, 16'd0);
        @(negedge clk);
        run_command(OP_WRITE, 8'hA5, 1'b0, NEVER_ACK);

        // zero unit length, zero ack timeout: give up on the first high sample
        start_phase(16'd0, 16'd0);
        run_command(OP_WRITE, 8'h5A, 1'b1, NEVER_ACK);
        run_command(OP_READ, 8'h96, 1'b0, 0);

        // longest unit, idle traffic only
        start_phase(16'hFFFF, 16'd2);
        idle_gap(20);

        directed_commands = command_count;
        active_items = 0;

        // random phases of mostly well-formed transfers with small units
        while (active_items < RANDOM_ITEMS || command_count < directed_commands + RANDOM_COMMANDS)
        begin
            tpu = 16'($urandom_range(0, 2));
            case ($urandom_range(0, 3))
                0: timeout = 16'd0;
                1: timeout = 16'd1;
                default: timeout = 16'($urandom_range(2, 6));
            endcase
            start_phase(tpu, timeout);
            if ($urandom_range(0, 4) != 0)
                random_transfer();
            else
                random_lone_command();
            idle_gap($urandom_range(0, 3));
            // first random phase: hold results back while requests keep coming
            if (!held)
            begin
                held = 1'b1;
                stall_request = 1'b1;
            end
        end

        wait_drained();
        if (expected_levels.size() != 0)
        begin
            failures++;
            $error("%0d predicted results never arrived", expected_levels.size());
        end

        $display("run covered %0d requests, %0d commands, %0d completions, %0d ack timeouts",
                 retired, command_count, completions, ack_timeouts);
        $display("%0d register writes: unit lengths 0..65535 and the reset 72, ack timeouts 0..250",
                 reg_writes);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== i2c_bit_master_top.f =====
rtl/core/i2cbm_pkg.sv
rtl/core/i2cbm_if.sv
rtl/core/i2cbm_cfg_regs.sv
rtl/core/i2cbm_step.sv
rtl/core/i2c_bit_master_top.sv
verif/testbench.sv
